### rtl/ptrc_pkg.sv
// shared types, constants and codes for the peer timestamp replay check
`timescale 1ns / 1ps

package ptrc_pkg;

   // default peer table depth
   localparam int PTRC_PEERS = 16;

   // field widths
   localparam int CMD_W     = 2;
   localparam int ADDR_W    = 32;
   localparam int PORT_W    = 16;
   localparam int STAMP_W   = 32;
   localparam int CNT_W     = 4;
   localparam int WIN_W     = 16;
   localparam int STATUS_W  = 2;
   localparam int CSR_AW    = 3;
   localparam int CSR_DW    = 32;

   // commands
   localparam logic [CMD_W-1:0] CMD_INIT  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_NEXT  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CHECK = 2'd2;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_PEER  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd2;

   // register select on paddr bit 2
   localparam logic CSR_SEL_MAX_OOO = 1'b0;
   localparam logic CSR_SEL_WINDOW  = 1'b1;

   // register reset values
   localparam logic [CNT_W-1:0] MAX_OOO_RESET = 4'd4;
   localparam logic [WIN_W-1:0] WINDOW_RESET  = 16'd60;

   // stale counter saturation
   localparam logic [CNT_W-1:0] CNT_SAT = 4'hF;

   // shared subtractor width: holds a 48 bit key difference with sign
   localparam int ALU_W = ADDR_W + PORT_W + 1;

   // tick difference / 1000 as multiply by ceil(2^38 / 1000) then shift by 38
   localparam int                 DIV_MAGIC_W = 29;
   localparam logic [DIV_MAGIC_W-1:0] DIV_MAGIC = 29'd274877907;
   localparam int                 DIV_SHIFT   = 38;
   localparam int                 PROD_W      = STAMP_W + DIV_MAGIC_W;
   localparam int                 ELAPSED_W   = PROD_W - DIV_SHIFT;

   // one peer table entry
   typedef struct packed {
      logic [ADDR_W-1:0]  addr;
      logic [PORT_W-1:0]  port;
      logic [STAMP_W-1:0] last_rx;
      logic [STAMP_W-1:0] next_tx;
      logic [CNT_W-1:0]   stale;
   } entry_type;

   // shared subtractor result
   typedef struct packed {
      logic [ALU_W-1:0] diff;
      logic             neg;
      logic             zero;
   } alu_res_type;

endpackage

### rtl/ptrc_ram.sv
// generic single port write, registered read ram
`timescale 1ns / 1ps

module ptrc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/ptrc_alu.sv
// shared subtractor with sign and zero flags
`timescale 1ns / 1ps

module ptrc_alu
   import ptrc_pkg::*;
(
   input  logic [ALU_W-1:0] op_a,
   input  logic [ALU_W-1:0] op_b,
   output alu_res_type      res
);

   logic [ALU_W-1:0] diff;

   // two's complement difference, operands fit in ALU_W-1 bits
   assign diff     = op_a - op_b;
   assign res.diff = diff;
   assign res.neg  = diff[ALU_W-1];
   assign res.zero = (diff == '0);

endmodule

### rtl/peer_timestamp_replay_check_core.sv
// peer timestamp replay check: peer table, sequencer and shared subtractor
`timescale 1ns / 1ps
//
//  channel   direction  handshake                       payload
//  req_      in         req_valid / req_stall           cmd, peer key, stamps, ticks
//  rsp_      out        rsp_valid / rsp_stall           accepted, send_stamp,
//                                                       stale_count, status
//  csr_      in/out     apb style psel/penable/pready   max_out_of_order, window
//
//  one item at a time: req_stall is high from the transfer until the result is
//  loaded into the output register; the next transfer can follow in the next cycle
//  transfer to result: linear peer search (ends early on a hit), execute, then
//  the limit check for a stale stamp or tick/mul/sub/sub/abs/cmp for the utc window
//  synchronous active high reset clears valid bits and state, presets the registers
//  a stalled result holds the sequencer in its final state, nothing is lost

module peer_timestamp_replay_check_core
   import ptrc_pkg::*;
#(
   parameter int PEERS = PTRC_PEERS
) (
   input  logic                clock,
   input  logic                reset,
   // request channel
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [CMD_W-1:0]    req_cmd,
   input  logic [ADDR_W-1:0]   req_peer_addr,
   input  logic [PORT_W-1:0]   req_peer_port,
   input  logic [STAMP_W-1:0]  req_stamp_value,
   input  logic                req_check_enable,
   input  logic                req_version_one,
   input  logic [STAMP_W-1:0]  req_ref_utc,
   input  logic [STAMP_W-1:0]  req_ref_tick,
   input  logic [STAMP_W-1:0]  req_now_tick,
   // response channel
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_accepted,
   output logic [STAMP_W-1:0]  rsp_send_stamp,
   output logic [CNT_W-1:0]    rsp_stale_count,
   output logic [STATUS_W-1:0] rsp_status,
   // register port
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [CSR_AW-1:0]   csr_paddr,
   input  logic [CSR_DW-1:0]   csr_pwdata,
   output logic [CSR_DW-1:0]   csr_prdata,
   output logic                csr_pready
);

   localparam int IDX_W = (PEERS > 1) ? $clog2(PEERS) : 1;
   localparam int CNT_SCAN_W = $clog2(PEERS + 1);
   localparam logic [IDX_W-1:0]      LAST_IDX   = IDX_W'(PEERS - 1);
   localparam logic [CNT_SCAN_W-1:0] SCAN_END   = CNT_SCAN_W'(PEERS);

   // sequencer states
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_SCAN  = 4'd1;
   localparam logic [3:0] S_EXEC  = 4'd2;
   localparam logic [3:0] S_STALE = 4'd3;
   localparam logic [3:0] S_VTICK = 4'd4;
   localparam logic [3:0] S_VMUL  = 4'd5;
   localparam logic [3:0] S_VSUB1 = 4'd6;
   localparam logic [3:0] S_VSUB2 = 4'd7;
   localparam logic [3:0] S_VABS  = 4'd8;
   localparam logic [3:0] S_VCMP  = 4'd9;
   localparam logic [3:0] S_DONE  = 4'd10;

   // control state
   logic [3:0]            state_ff, state_in;
   logic [PEERS-1:0]      valid_ff, valid_in;
   logic                  rd_pend_ff, rd_pend_in;
   logic                  found_ff, found_in;
   logic                  free_ok_ff, free_ok_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]      max_ooo_ff, max_ooo_in;
   logic [WIN_W-1:0]      win_ff, win_in;

   // item payload and working registers
   logic [CMD_W-1:0]      cmd_ff, cmd_in;
   logic [ADDR_W-1:0]     addr_ff, addr_in;
   logic [PORT_W-1:0]     port_ff, port_in;
   logic [STAMP_W-1:0]    stamp_ff, stamp_in;
   logic                  en_ff, en_in;
   logic                  v1_ff, v1_in;
   logic [STAMP_W-1:0]    utc_ff, utc_in;
   logic [STAMP_W-1:0]    rtick_ff, rtick_in;
   logic [STAMP_W-1:0]    ntick_ff, ntick_in;
   logic [CNT_SCAN_W-1:0] scan_ff, scan_in;
   logic [IDX_W-1:0]      cmp_idx_ff, cmp_idx_in;
   logic [IDX_W-1:0]      fidx_ff, fidx_in;
   logic [IDX_W-1:0]      free_idx_ff, free_idx_in;
   entry_type             ent_ff, ent_in;
   logic [ALU_W-1:0]      tmp_ff, tmp_in;
   logic [PROD_W-1:0]     prod_ff, prod_in;

   // result being built, then the output register
   logic                  res_acc_ff, res_acc_in;
   logic [STAMP_W-1:0]    res_send_ff, res_send_in;
   logic [CNT_W-1:0]      res_stale_ff, res_stale_in;
   logic [STATUS_W-1:0]   res_status_ff, res_status_in;
   logic                  rsp_acc_ff, rsp_acc_in;
   logic [STAMP_W-1:0]    rsp_send_ff, rsp_send_in;
   logic [CNT_W-1:0]      rsp_stale_ff, rsp_stale_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;

   // ram and subtractor hookup
   logic                  ram_wr_en;
   logic [IDX_W-1:0]      ram_wr_addr;
   entry_type             ram_wr_data;
   logic                  ram_rd_en;
   logic [IDX_W-1:0]      ram_rd_addr;
   entry_type             ram_rd_data;
   logic [ALU_W-1:0]      alu_a, alu_b;
   alu_res_type           alu_res;

   logic                  req_xfer;
   logic                  csr_wr;
   logic                  rsp_free;
   logic [ELAPSED_W-1:0]  elapsed;
   logic [CNT_W-1:0]      stale_bump;

   assign req_stall = (state_ff != S_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign csr_wr    = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   // elapsed seconds from the registered reciprocal product
   assign elapsed    = prod_ff[DIV_SHIFT +: ELAPSED_W];
   // saturating stale increment
   assign stale_bump = (ent_ff.stale == CNT_SAT) ? ent_ff.stale : ent_ff.stale + 1'b1;

   ptrc_ram #(
      .WIDTH($bits(entry_type)),
      .DEPTH(PEERS)
   ) u_peer_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   ptrc_alu u_alu (
      .op_a (alu_a),
      .op_b (alu_b),
      .res  (alu_res)
   );

   // operand selection for the shared subtractor
   always_comb begin
      alu_a = '0;
      alu_b = '0;
      case (state_ff)
         S_SCAN: begin
            // key match: zero difference
            alu_a = ALU_W'({addr_ff, port_ff});
            alu_b = ALU_W'({ram_rd_data.addr, ram_rd_data.port});
         end
         S_EXEC: begin
            if (cmd_ff == CMD_NEXT) begin
               // minus minus one gives the increment
               alu_a = ALU_W'(ent_ff.next_tx);
               alu_b = '1;
            end else begin
               // ordering: negative means the stamp is newer
               alu_a = ALU_W'(ent_ff.last_rx);
               alu_b = ALU_W'(stamp_ff);
            end
         end
         S_STALE: begin
            alu_a = ALU_W'(max_ooo_ff);
            alu_b = ALU_W'(ent_ff.stale);
         end
         S_VTICK: begin
            alu_a = ALU_W'(ntick_ff);
            alu_b = ALU_W'(rtick_ff);
         end
         S_VSUB1: begin
            alu_a = ALU_W'(stamp_ff);
            alu_b = ALU_W'(utc_ff);
         end
         S_VSUB2: begin
            alu_a = tmp_ff;
            alu_b = ALU_W'(elapsed);
         end
         S_VABS: begin
            alu_a = '0;
            alu_b = tmp_ff;
         end
         S_VCMP: begin
            alu_a = ALU_W'(win_ff);
            alu_b = tmp_ff;
         end
         default: begin
            alu_a = '0;
            alu_b = '0;
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      valid_in      = valid_ff;
      rd_pend_in    = rd_pend_ff;
      found_in      = found_ff;
      free_ok_in    = free_ok_ff;
      rsp_valid_in  = rsp_valid_ff;
      max_ooo_in    = max_ooo_ff;
      win_in        = win_ff;

      cmd_in        = cmd_ff;
      addr_in       = addr_ff;
      port_in       = port_ff;
      stamp_in      = stamp_ff;
      en_in         = en_ff;
      v1_in         = v1_ff;
      utc_in        = utc_ff;
      rtick_in      = rtick_ff;
      ntick_in      = ntick_ff;
      scan_in       = scan_ff;
      cmp_idx_in    = cmp_idx_ff;
      fidx_in       = fidx_ff;
      free_idx_in   = free_idx_ff;
      ent_in        = ent_ff;
      tmp_in        = tmp_ff;
      prod_in       = prod_ff;

      res_acc_in    = res_acc_ff;
      res_send_in   = res_send_ff;
      res_stale_in  = res_stale_ff;
      res_status_in = res_status_ff;
      rsp_acc_in    = rsp_acc_ff;
      rsp_send_in   = rsp_send_ff;
      rsp_stale_in  = rsp_stale_ff;
      rsp_status_in = rsp_status_ff;

      ram_wr_en     = 1'b0;
      ram_wr_addr   = fidx_ff;
      ram_wr_data   = ent_ff;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = scan_ff[IDX_W-1:0];

      // register writes, byte offset bits ignored
      if (csr_wr) begin
         if (csr_paddr[2] == CSR_SEL_MAX_OOO) begin
            max_ooo_in = csr_pwdata[CNT_W-1:0];
         end else begin
            win_in = csr_pwdata[WIN_W-1:0];
         end
      end

      // output register drains on its transfer
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               cmd_in        = req_cmd;
               addr_in       = req_peer_addr;
               port_in       = req_peer_port;
               stamp_in      = req_stamp_value;
               en_in         = req_check_enable;
               v1_in         = req_version_one;
               utc_in        = req_ref_utc;
               rtick_in      = req_ref_tick;
               ntick_in      = req_now_tick;
               scan_in       = '0;
               rd_pend_in    = 1'b0;
               found_in      = 1'b0;
               free_ok_in    = 1'b0;
               res_acc_in    = 1'b0;
               res_send_in   = '0;
               res_stale_in  = '0;
               res_status_in = STATUS_OK;
               // unused command: no lookup, all zero result
               if (req_cmd == CMD_INIT || req_cmd == CMD_NEXT || req_cmd == CMD_CHECK) begin
                  state_in = S_SCAN;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_SCAN: begin
            // issue the next read while comparing the previous one
            if (scan_ff != SCAN_END) begin
               ram_rd_en  = 1'b1;
               scan_in    = scan_ff + 1'b1;
               rd_pend_in = 1'b1;
               cmp_idx_in = scan_ff[IDX_W-1:0];
            end else begin
               rd_pend_in = 1'b0;
            end
            if (rd_pend_ff) begin
               if (valid_ff[cmp_idx_ff] && alu_res.zero) begin
                  found_in   = 1'b1;
                  fidx_in    = cmp_idx_ff;
                  ent_in     = ram_rd_data;
                  rd_pend_in = 1'b0;
                  state_in   = S_EXEC;
               end else begin
                  // lowest free slot for an insert
                  if (!valid_ff[cmp_idx_ff] && !free_ok_ff) begin
                     free_ok_in  = 1'b1;
                     free_idx_in = cmp_idx_ff;
                  end
                  if (cmp_idx_ff == LAST_IDX) begin
                     rd_pend_in = 1'b0;
                     state_in   = S_EXEC;
                  end
               end
            end
         end
         S_EXEC: begin
            state_in     = S_DONE;
            res_stale_in = found_ff ? ent_ff.stale : '0;
            case (cmd_ff)
               CMD_INIT: begin
                  if (found_ff) begin
                     ram_wr_en           = 1'b1;
                     ram_wr_addr         = fidx_ff;
                     ram_wr_data.next_tx = stamp_ff;
                  end else if (free_ok_ff) begin
                     ram_wr_en             = 1'b1;
                     ram_wr_addr           = free_idx_ff;
                     ram_wr_data.addr      = addr_ff;
                     ram_wr_data.port      = port_ff;
                     ram_wr_data.last_rx   = '0;
                     ram_wr_data.next_tx   = stamp_ff;
                     ram_wr_data.stale     = '0;
                     valid_in[free_idx_ff] = 1'b1;
                  end else begin
                     res_status_in = STATUS_FULL;
                  end
               end
               CMD_NEXT: begin
                  if (found_ff) begin
                     ram_wr_en           = 1'b1;
                     ram_wr_addr         = fidx_ff;
                     ram_wr_data.next_tx = alu_res.diff[STAMP_W-1:0];
                     res_send_in         = alu_res.diff[STAMP_W-1:0];
                  end else begin
                     res_status_in = STATUS_NO_PEER;
                  end
               end
               CMD_CHECK: begin
                  if (!en_ff) begin
                     res_acc_in = 1'b1;
                  end else if (v1_ff) begin
                     state_in = S_VTICK;
                  end else if (!found_ff) begin
                     res_status_in = STATUS_NO_PEER;
                  end else if (!alu_res.neg) begin
                     // stamp not newer than the last one
                     state_in = S_STALE;
                  end else begin
                     ram_wr_en           = 1'b1;
                     ram_wr_addr         = fidx_ff;
                     ram_wr_data.last_rx = stamp_ff;
                     ram_wr_data.stale   = '0;
                     res_acc_in          = 1'b1;
                     res_stale_in        = '0;
                  end
               end
               default: begin
                  res_stale_in = '0;
               end
            endcase
         end
         S_STALE: begin
            state_in = S_DONE;
            // tolerated while count is within the limit
            if (!alu_res.neg) begin
               ram_wr_en         = 1'b1;
               ram_wr_addr       = fidx_ff;
               ram_wr_data.stale = stale_bump;
               res_acc_in        = 1'b1;
               res_stale_in      = stale_bump;
            end
         end
         S_VTICK: begin
            // tick difference wraps at 32 bits
            tmp_in   = ALU_W'(alu_res.diff[STAMP_W-1:0]);
            state_in = S_VMUL;
         end
         S_VMUL: begin
            prod_in  = PROD_W'(tmp_ff[STAMP_W-1:0]) * PROD_W'(DIV_MAGIC);
            state_in = S_VSUB1;
         end
         S_VSUB1: begin
            tmp_in   = alu_res.diff;
            state_in = S_VSUB2;
         end
         S_VSUB2: begin
            tmp_in   = alu_res.diff;
            state_in = S_VABS;
         end
         S_VABS: begin
            // magnitude of the skew
            tmp_in   = tmp_ff[ALU_W-1] ? alu_res.diff : tmp_ff;
            state_in = S_VCMP;
         end
         S_VCMP: begin
            res_acc_in = !alu_res.neg;
            state_in   = S_DONE;
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_acc_in    = res_acc_ff;
               rsp_send_in   = res_send_ff;
               rsp_stale_in  = res_stale_ff;
               rsp_status_in = res_status_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         rd_pend_ff   <= 1'b0;
         found_ff     <= 1'b0;
         free_ok_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         max_ooo_ff   <= MAX_OOO_RESET;
         win_ff       <= WINDOW_RESET;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         rd_pend_ff   <= rd_pend_in;
         found_ff     <= found_in;
         free_ok_ff   <= free_ok_in;
         rsp_valid_ff <= rsp_valid_in;
         max_ooo_ff   <= max_ooo_in;
         win_ff       <= win_in;
      end
   end

   // payload and working registers
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      addr_ff       <= addr_in;
      port_ff       <= port_in;
      stamp_ff      <= stamp_in;
      en_ff         <= en_in;
      v1_ff         <= v1_in;
      utc_ff        <= utc_in;
      rtick_ff      <= rtick_in;
      ntick_ff      <= ntick_in;
      scan_ff       <= scan_in;
      cmp_idx_ff    <= cmp_idx_in;
      fidx_ff       <= fidx_in;
      free_idx_ff   <= free_idx_in;
      ent_ff        <= ent_in;
      tmp_ff        <= tmp_in;
      prod_ff       <= prod_in;
      res_acc_ff    <= res_acc_in;
      res_send_ff   <= res_send_in;
      res_stale_ff  <= res_stale_in;
      res_status_ff <= res_status_in;
      rsp_acc_ff    <= rsp_acc_in;
      rsp_send_ff   <= rsp_send_in;
      rsp_stale_ff  <= rsp_stale_in;
      rsp_status_ff <= rsp_status_in;
   end

   // register read back
   assign csr_prdata = (csr_paddr[2] == CSR_SEL_MAX_OOO) ? CSR_DW'(max_ooo_ff) : CSR_DW'(win_ff);
   assign csr_pready = 1'b1;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_accepted    = rsp_acc_ff;
   assign rsp_send_stamp  = rsp_send_ff;
   assign rsp_stale_count = rsp_stale_ff;
   assign rsp_status      = rsp_status_ff;

endmodule

### tb/sv/testbench.sv
// self-checking testbench for the peer timestamp replay check core
`timescale 1ns / 1ps

module testbench;
   import ptrc_pkg::*;

   // ------------------------------------------------------------------
   // run parameters
   // ------------------------------------------------------------------
   localparam int CYCLE_LIMIT   = 1_000_000;
   // covers the longest item, a utc window check after a full peer search, still in flight
   localparam int SETTLE_CYCLES = 2 * PTRC_PEERS + 10;
   localparam int KEY_POOL      = 22;    // more keys than table entries
   localparam int PHASE_ITEMS   = 320;

   // the one command code the package leaves unnamed
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   // directed keys at the extremes of the key fields
   localparam logic [ADDR_W-1:0] KEY_A_ADDR = '0;
   localparam logic [PORT_W-1:0] KEY_A_PORT = '0;
   localparam logic [ADDR_W-1:0] KEY_B_ADDR = '1;
   localparam logic [PORT_W-1:0] KEY_B_PORT = '1;

   // utc window case: reference tick just below the wrap, 123 s elapsed
   localparam logic [STAMP_W-1:0] V1_UTC    = 32'd1000;
   localparam logic [STAMP_W-1:0] V1_TICK   = 32'hFFFF_0000;
   localparam logic [STAMP_W-1:0] V1_NOW    = V1_TICK + 32'd123456;
   localparam logic [STAMP_W-1:0] V1_CENTRE = V1_UTC + 32'd123;

   typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_type;

   typedef struct packed {
      logic [CMD_W-1:0]   cmd;
      logic [ADDR_W-1:0]  addr;
      logic [PORT_W-1:0]  port;
      logic [STAMP_W-1:0] stamp;
      logic               check_en;
      logic               v1;
      logic [STAMP_W-1:0] ref_utc;
      logic [STAMP_W-1:0] ref_tick;
      logic [STAMP_W-1:0] now_tick;
   } stamp_request_type;

   typedef struct packed {
      logic               accepted;
      logic [STAMP_W-1:0] send_stamp;
      logic [CNT_W-1:0]   stale_count;
      logic [STATUS_W-1:0] status;
   } stamp_verdict_type;

   // ------------------------------------------------------------------
   // clock, dut ports
   // ------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   logic                req_valid;
   logic                req_stall;
   logic [CMD_W-1:0]    req_cmd;
   logic [ADDR_W-1:0]   req_peer_addr;
   logic [PORT_W-1:0]   req_peer_port;
   logic [STAMP_W-1:0]  req_stamp_value;
   logic                req_check_enable;
   logic                req_version_one;
   logic [STAMP_W-1:0]  req_ref_utc;
   logic [STAMP_W-1:0]  req_ref_tick;
   logic [STAMP_W-1:0]  req_now_tick;
   logic                rsp_valid;
   logic                rsp_stall;
   logic                rsp_accepted;
   logic [STAMP_W-1:0]  rsp_send_stamp;
   logic [CNT_W-1:0]    rsp_stale_count;
   logic [STATUS_W-1:0] rsp_status;
   logic                csr_psel;
   logic                csr_penable;
   logic                csr_pwrite;
   logic [CSR_AW-1:0]   csr_paddr;
   logic [CSR_DW-1:0]   csr_pwdata;
   logic [CSR_DW-1:0]   csr_prdata;
   logic                csr_pready;

   peer_timestamp_replay_check_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd          (req_cmd),
      .req_peer_addr    (req_peer_addr),
      .req_peer_port    (req_peer_port),
      .req_stamp_value  (req_stamp_value),
      .req_check_enable (req_check_enable),
      .req_version_one  (req_version_one),
      .req_ref_utc      (req_ref_utc),
      .req_ref_tick     (req_ref_tick),
      .req_now_tick     (req_now_tick),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_accepted     (rsp_accepted),
      .rsp_send_stamp   (rsp_send_stamp),
      .rsp_stale_count  (rsp_stale_count),
      .rsp_status       (rsp_status),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   // ------------------------------------------------------------------
   // shadow of the peer table and registers
   // ------------------------------------------------------------------
   entry_type        peer_table [PTRC_PEERS];
   bit               slot_used  [PTRC_PEERS];
   logic [CNT_W-1:0] cfg_max_ooo = MAX_OOO_RESET;
   logic [WIN_W-1:0] cfg_window  = WINDOW_RESET;

   stamp_verdict_type pending_verdicts [$];   // one per accepted request, oldest first

   logic [ADDR_W-1:0] pool_addr [KEY_POOL];
   logic [PORT_W-1:0] pool_port [KEY_POOL];

   int failures    = 0;
   int cycle_count = 0;
   int burst_left  = 0;
   int stall_hold  = 0;    // long receiver hold-off, counted down by the receiver

   // lowest-index live entry with this key, -1 when absent
   function automatic int find_slot(logic [ADDR_W-1:0] addr, logic [PORT_W-1:0] port);
      for (int i = 0; i < PTRC_PEERS; i++)
         if (slot_used[i] && peer_table[i].addr == addr && peer_table[i].port == port)
            return i;
      return -1;
   endfunction

   // version one: exact signed skew against utc plus whole seconds elapsed
   function automatic bit utc_window_ok(stamp_request_type rq);
      logic [STAMP_W-1:0] span;
      longint elapsed_s, skew, limit_s;
      span      = rq.now_tick - rq.ref_tick;
      elapsed_s = longint'(span);
      elapsed_s = elapsed_s / 1000;
      skew      = longint'(rq.stamp);
      limit_s   = longint'(rq.ref_utc);
      skew      = skew - limit_s - elapsed_s;
      if (skew < 0)
         skew = -skew;
      limit_s = longint'(cfg_window);
      return skew <= limit_s;
   endfunction

   // applies one request to the shadow table and returns the result it causes
   function automatic stamp_verdict_type replay_table_step(stamp_request_type rq);
      stamp_verdict_type v;
      int slot;
      v    = '0;
      slot = find_slot(rq.addr, rq.port);
      case (rq.cmd)
         CMD_INIT: begin
            if (slot >= 0) begin
               peer_table[slot].next_tx = rq.stamp;
            end else begin
               for (int i = 0; i < PTRC_PEERS && slot < 0; i++)
                  if (!slot_used[i])
                     slot = i;
               if (slot >= 0) begin
                  slot_used[slot]  = 1'b1;
                  peer_table[slot] = '{addr: rq.addr, port: rq.port, last_rx: '0,
                                       next_tx: rq.stamp, stale: '0};
               end else begin
                  v.status = STATUS_FULL;
               end
            end
         end
         CMD_NEXT: begin
            if (slot >= 0) begin
               peer_table[slot].next_tx = peer_table[slot].next_tx + 1'b1;
               v.send_stamp             = peer_table[slot].next_tx;
            end else begin
               v.status = STATUS_NO_PEER;
            end
         end
         CMD_CHECK: begin
            if (!rq.check_en) begin
               v.accepted = 1'b1;
            end else if (rq.v1) begin
               v.accepted = utc_window_ok(rq);
            end else if (slot < 0) begin
               v.status = STATUS_NO_PEER;
            end else if (peer_table[slot].last_rx >= rq.stamp) begin
               // stale stamp: tolerated while the count is within the limit
               if (peer_table[slot].stale <= cfg_max_ooo) begin
                  if (peer_table[slot].stale != CNT_SAT)
                     peer_table[slot].stale = peer_table[slot].stale + 1'b1;
                  v.accepted = 1'b1;
               end
            end else begin
               peer_table[slot].last_rx = rq.stamp;
               peer_table[slot].stale   = '0;
               v.accepted               = 1'b1;
            end
         end
         default: slot = -1;
      endcase
      if (slot >= 0)
         v.stale_count = peer_table[slot].stale;
      return v;
   endfunction

   function automatic stamp_request_type build_request(
      logic [CMD_W-1:0] cmd, logic [ADDR_W-1:0] addr, logic [PORT_W-1:0] port,
      logic [STAMP_W-1:0] stamp, logic check_en, logic v1,
      logic [STAMP_W-1:0] ref_utc, logic [STAMP_W-1:0] ref_tick,
      logic [STAMP_W-1:0] now_tick);
      stamp_request_type rq;
      rq = '{cmd: cmd, addr: addr, port: port, stamp: stamp, check_en: check_en, v1: v1,
             ref_utc: ref_utc, ref_tick: ref_tick, now_tick: now_tick};
      return rq;
   endfunction

   // mostly well-formed traffic on known keys, some unknown keys and odd commands
   function automatic stamp_request_type random_request();
      stamp_request_type rq;
      int pick, k, slot;
      logic [STAMP_W-1:0] span, prior, off_bits;
      longint off;
      pick = $urandom_range(0, 19);
      if (pick < 4)
         rq.cmd = CMD_INIT;
      else if (pick < 8)
         rq.cmd = CMD_NEXT;
      else if (pick < 19)
         rq.cmd = CMD_CHECK;
      else
         rq.cmd = CMD_UNUSED;
      if ($urandom_range(0, 6) != 0) begin
         k       = $urandom_range(0, KEY_POOL - 1);
         rq.addr = pool_addr[k];
         rq.port = pool_port[k];
      end else begin
         rq.addr = $urandom;
         rq.port = PORT_W'($urandom);
      end
      rq.stamp    = $urandom;
      rq.check_en = ($urandom_range(0, 9) != 0);
      rq.v1       = ($urandom_range(0, 2) == 0);
      rq.ref_utc  = $urandom;
      rq.ref_tick = $urandom;
      rq.now_tick = $urandom;
      if (rq.cmd == CMD_CHECK && rq.check_en && rq.v1) begin
         // aim at the window edges, tick difference sometimes wrapping
         if ($urandom_range(0, 3) != 0)
            rq.now_tick = rq.ref_tick + $urandom_range(0, 3_600_000);
         span = (rq.now_tick - rq.ref_tick) / 32'd1000;
         case ($urandom_range(0, 3))
            0:       off = longint'(cfg_window);
            1:       off = longint'(cfg_window) + 1;
            2:       off = longint'($urandom_range(0, 2 * cfg_window + 2));
            default: off = longint'($urandom);
         endcase
         if ($urandom_range(0, 1) != 0)
            off = -off;
         off_bits = STAMP_W'(off);
         rq.stamp = rq.ref_utc + span + off_bits;
      end else if (rq.cmd == CMD_CHECK && rq.check_en) begin
         // ordering check: newer stamps and short stale runs
         slot = find_slot(rq.addr, rq.port);
         if (slot >= 0) begin
            prior = peer_table[slot].last_rx;
            pick  = $urandom_range(0, 9);
            if (pick < 5)
               rq.stamp = prior + $urandom_range(1, 500);
            else if (pick < 9)
               rq.stamp = prior - $urandom_range(0, 20);
         end
      end
      return rq;
   endfunction

   // ------------------------------------------------------------------
   // request side: one transfer, then maybe a gap between bursts
   // ------------------------------------------------------------------
   task automatic send_request(stamp_request_type rq);
      int gap;
      @(negedge clock);
      req_valid        = 1'b1;
      req_cmd          = rq.cmd;
      req_peer_addr    = rq.addr;
      req_peer_port    = rq.port;
      req_stamp_value  = rq.stamp;
      req_check_enable = rq.check_en;
      req_version_one  = rq.v1;
      req_ref_utc      = rq.ref_utc;
      req_ref_tick     = rq.ref_tick;
      req_now_tick     = rq.now_tick;
      forever begin
         @(posedge clock);
         if (req_stall === 1'b0)
            break;
      end
      pending_verdicts.push_back(replay_table_step(rq));
      if (burst_left > 0)
         burst_left--;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         case ($urandom_range(0, 3))
            1:       gap = $urandom_range(1, 4);
            2:       gap = $urandom_range(5, 30);
            default: gap = 0;
         endcase
         if (gap > 0) begin
            @(negedge clock);
            req_valid = 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
   endtask

   // drop valid and hold off until every outstanding result has come back
   task automatic wait_drained();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_verdicts.size() != 0)
         @(posedge clock);
   endtask

   // register write (setup + access) followed by a read-back
   task automatic csr_write_verify(logic sel, logic [CSR_DW-1:0] value);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_pwrite  = 1'b1;
      csr_penable = 1'b0;
      csr_paddr   = {sel, 2'b00};
      csr_pwdata  = value;
      @(negedge clock);
      csr_penable = 1'b1;
      forever begin
         @(posedge clock);
         if (csr_pready === 1'b1)
            break;
      end
      @(negedge clock);
      csr_pwrite  = 1'b0;
      csr_penable = 1'b0;
      @(negedge clock);
      csr_penable = 1'b1;
      forever begin
         @(posedge clock);
         if (csr_pready === 1'b1)
            break;
      end
      if (csr_prdata !== value) begin
         $error("csr read-back at %0h: expected %0h, got %0h", csr_paddr, value, csr_prdata);
         failures++;
      end
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
   endtask

   // registers change only with the core idle
   task automatic apply_settings(logic [CNT_W-1:0] max_ooo, logic [WIN_W-1:0] window);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write_verify(CSR_SEL_MAX_OOO, CSR_DW'(max_ooo));
      cfg_max_ooo = max_ooo;
      csr_write_verify(CSR_SEL_WINDOW, CSR_DW'(window));
      cfg_window = window;
   endtask

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------

   // key extremes, every command, stale limit, utc window edges, unused command
   task automatic test_directed_cases();
      // unknown peer on check and next-send
      send_request(build_request(CMD_CHECK, KEY_A_ADDR, KEY_A_PORT, 32'h1, 1'b1, 1'b0, 0, 0, 0));
      send_request(build_request(CMD_NEXT, KEY_A_ADDR, KEY_A_PORT, 0, 1'b0, 1'b0, 0, 0, 0));
      // insert, send stamp wraps, then update of an existing peer
      send_request(build_request(CMD_INIT, KEY_A_ADDR, KEY_A_PORT, '1, 1'b0, 1'b0, 0, 0, 0));
      send_request(build_request(CMD_NEXT, KEY_A_ADDR, KEY_A_PORT, 0, 1'b0, 1'b0, 0, 0, 0));
      send_request(build_request(CMD_INIT, KEY_A_ADDR, KEY_A_PORT, 32'd5, 1'b1, 1'b1, 0, 0, 0));
      send_request(build_request(CMD_NEXT, KEY_A_ADDR, KEY_A_PORT, 0, 1'b0, 1'b0, 0, 0, 0));
      // second peer at the top of the key range, stale run past the limit
      send_request(build_request(CMD_INIT, KEY_B_ADDR, KEY_B_PORT, 0, 1'b0, 1'b0, 0, 0, 0));
      for (int n = 0; n < 6; n++)
         send_request(build_request(CMD_CHECK, KEY_B_ADDR, KEY_B_PORT, 0, 1'b1, 1'b0, 0, 0, 0));
      // newer stamp clears the count
      send_request(build_request(CMD_CHECK, KEY_B_ADDR, KEY_B_PORT, '1, 1'b1, 1'b0, 0, 0, 0));
      // checking disabled, known and unknown peer
      send_request(build_request(CMD_CHECK, KEY_B_ADDR, KEY_B_PORT, 0, 1'b0, 1'b0, 0, 0, 0));
      send_request(build_request(CMD_CHECK, 32'h1, 16'h1, 0, 1'b0, 1'b1, 0, 0, 0));
      // utc window: just inside and just outside on both sides
      send_request(build_request(CMD_CHECK, KEY_A_ADDR, KEY_A_PORT, V1_CENTRE + WINDOW_RESET,
                                 1'b1, 1'b1, V1_UTC, V1_TICK, V1_NOW));
      send_request(build_request(CMD_CHECK, KEY_A_ADDR, KEY_A_PORT,
                                 V1_CENTRE + WINDOW_RESET + 1, 1'b1, 1'b1, V1_UTC, V1_TICK, V1_NOW));
      send_request(build_request(CMD_CHECK, 32'h7, 16'h7, V1_CENTRE - WINDOW_RESET,
                                 1'b1, 1'b1, V1_UTC, V1_TICK, V1_NOW));
      send_request(build_request(CMD_CHECK, 32'h7, 16'h7, V1_CENTRE - WINDOW_RESET - 1,
                                 1'b1, 1'b1, V1_UTC, V1_TICK, V1_NOW));
      // skew at the full 32 bit range either way
      send_request(build_request(CMD_CHECK, KEY_B_ADDR, KEY_B_PORT, 0, 1'b1, 1'b1, '1, 0, 0));
      send_request(build_request(CMD_CHECK, KEY_B_ADDR, KEY_B_PORT, '1, 1'b1, 1'b1, 0, '1, 0));
      // unused command code
      send_request(build_request(CMD_UNUSED, KEY_A_ADDR, KEY_A_PORT, '1, 1'b1, 1'b1, '1, '1, '1));
   endtask

   task automatic test_random_traffic(logic [CNT_W-1:0] max_ooo, logic [WIN_W-1:0] window,
                                      int count);
      apply_settings(max_ooo, window);
      repeat (count)
         send_request(random_request());
   endtask

   // highest tolerance: the stale count must stop at its ceiling and keep accepting
   task automatic test_stale_saturation();
      apply_settings(CNT_SAT, '1);
      repeat (20)
         send_request(build_request(CMD_CHECK, KEY_B_ADDR, KEY_B_PORT, $urandom, 1'b1, 1'b0,
                                    $urandom, $urandom, $urandom));
   endtask

   // receiver holds off long enough for the core to fill and stall its input
   task automatic test_result_backpressure();
      wait_drained();
      stall_hold = 400;
      repeat (10)
         send_request(random_request());
      wait_drained();
   endtask

   // ------------------------------------------------------------------
   // result side: stall pattern and checking
   // ------------------------------------------------------------------
   initial begin
      stall_mode_type mode;
      int mode_left;
      rsp_stall = 1'b0;
      mode      = STALL_NONE;
      mode_left = 0;
      forever begin
         @(negedge clock);
         if (stall_hold > 0) begin
            rsp_stall = 1'b1;
            stall_hold--;
         end else begin
            if (mode_left == 0) begin
               mode      = stall_mode_type'($urandom_range(0, 3));
               mode_left = $urandom_range(20, 300);
            end
            mode_left--;
            case (mode)
               STALL_LIGHT:    rsp_stall = ($urandom_range(0, 3) == 0);
               STALL_HEAVY:    rsp_stall = ($urandom_range(0, 3) != 0);
               STALL_PERIODIC: rsp_stall = ((mode_left % 7) < 3);
               default:        rsp_stall = 1'b0;
            endcase
         end
      end
   end

   task automatic check_field(string field, logic [STAMP_W-1:0] want, logic [STAMP_W-1:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0h, got %0h", field, want, got);
         failures++;
      end
   endtask

   // every result transfer is matched against the oldest expectation
   initial begin
      stamp_verdict_type want;
      forever begin
         @(posedge clock);
         if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            if (pending_verdicts.size() == 0) begin
               $error("result transfer with no request outstanding");
               failures++;
            end else begin
               want = pending_verdicts.pop_front();
               check_field("accepted", STAMP_W'(want.accepted), STAMP_W'(rsp_accepted));
               check_field("send_stamp", want.send_stamp, rsp_send_stamp);
               check_field("stale_count", STAMP_W'(want.stale_count),
                           STAMP_W'(rsp_stale_count));
               check_field("status", STAMP_W'(want.status), STAMP_W'(rsp_status));
            end
         end
      end
   end

   // watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[peer_timestamp_replay_check_core] ERROR");
      $finish;
   end

   // ------------------------------------------------------------------
   // sequence of tests
   // ------------------------------------------------------------------
   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_cmd          = CMD_INIT;
      req_peer_addr    = '0;
      req_peer_port    = '0;
      req_stamp_value  = '0;
      req_check_enable = 1'b0;
      req_version_one  = 1'b0;
      req_ref_utc      = '0;
      req_ref_tick     = '0;
      req_now_tick     = '0;
      csr_psel         = 1'b0;
      csr_penable      = 1'b0;
      csr_pwrite       = 1'b0;
      csr_paddr        = '0;
      csr_pwdata       = '0;
      for (int i = 0; i < PTRC_PEERS; i++)
         slot_used[i] = 1'b0;
      // key pool with near misses: shared address, shared port
      for (int k = 0; k < KEY_POOL; k++) begin
         pool_addr[k] = $urandom;
         pool_port[k] = PORT_W'($urandom);
      end
      pool_addr[1] = pool_addr[0];
      pool_port[2] = pool_port[0];

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_cases();
      test_random_traffic(MAX_OOO_RESET, WINDOW_RESET, PHASE_ITEMS);
      test_random_traffic('0, '0, PHASE_ITEMS);
      test_stale_saturation();
      test_random_traffic(CNT_SAT, '1, PHASE_ITEMS);
      test_result_backpressure();
      test_random_traffic(CNT_W'($urandom), WIN_W'($urandom_range(0, 300)), PHASE_ITEMS);
      test_random_traffic(CNT_W'($urandom), WIN_W'($urandom), PHASE_ITEMS);

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (failures == 0 && pending_verdicts.size() == 0)
         $display("[peer_timestamp_replay_check_core] OK");
      else
         $display("[peer_timestamp_replay_check_core] ERROR");
      $finish;
   end

endmodule

### files.f
rtl/ptrc_pkg.sv
rtl/ptrc_ram.sv
rtl/ptrc_alu.sv
rtl/peer_timestamp_replay_check_core.sv
tb/sv/testbench.sv
